// ===== rtl/core/pcbs_pkg.sv =====
// ----------------------------------------------------------------------------
// pcbs_pkg
// Shared types, widths and constants of the per-class box suppression block.
// ----------------------------------------------------------------------------
`default_nettype none

package pcbs_pkg;

	// defaults for the top-level parameters
	localparam int KEPT_MAX_DEF  = 64;
	localparam int FRAC_BITS_DEF = 4;

	// overlap threshold register, in 256ths
	localparam int             THR_W     = 9;
	localparam logic [THR_W-1:0] THR_RESET = 9'd115;

	// intersection is scaled by 256 before the compare
	localparam int IOU_SH = 8;

	// field widths fixed by the interface
	localparam int POS_W   = 16;
	localparam int EDGE_W  = 18;
	localparam int CLASS_W = 7;
	localparam int TAG_W   = 16;
	localparam int COORD_W = 19;

	typedef logic signed [COORD_W-1:0] coord_t;

	// one stored box: left/top as received, right/bottom as left+width, top+height
	typedef struct packed {
		logic signed [POS_W-1:0]  left;
		logic signed [POS_W-1:0]  top;
		logic signed [EDGE_W-1:0] right;
		logic signed [EDGE_W-1:0] bottom;
		logic [CLASS_W-1:0]       cls;
	} box_t;

	// overlap pipeline status towards the controller
	typedef struct packed {
		logic busy;
		logic hit;
	} iou_status_t;

	// bits needed for an inclusive span: size plus one pixel
	function automatic int span_width(input int frac_bits);
		return $clog2(65535 + (2 ** frac_bits) + 1);
	endfunction

	function automatic coord_t ext_pos(input logic [POS_W-1:0] v);
		return $signed({{(COORD_W-POS_W){v[POS_W-1]}}, v});
	endfunction

	function automatic coord_t ext_edge(input logic [EDGE_W-1:0] v);
		return $signed({{(COORD_W-EDGE_W){v[EDGE_W-1]}}, v});
	endfunction

endpackage

`default_nettype wire

// ===== rtl/core/pcbs_kept_mem.sv =====
// ----------------------------------------------------------------------------
// pcbs_kept_mem
// Store of kept boxes: one write port, one read port, registered read data.
// ----------------------------------------------------------------------------
`default_nettype none

module pcbs_kept_mem #(
	parameter int DEPTH = pcbs_pkg::KEPT_MAX_DEF
) (
	input  wire                         clk,
	input  wire                         arst_n,
	input  wire                         we,
	input  wire  [$clog2(DEPTH)-1:0]    waddr,
	input  pcbs_pkg::box_t              wdata,
	input  wire                         re,
	input  wire  [$clog2(DEPTH)-1:0]    raddr,
	output pcbs_pkg::box_t              rdata,
	output logic                        rvalid
);
	import pcbs_pkg::*;

	box_t mem_q [DEPTH];

	// write port
	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
	end

	// read port, registered read data
	always_ff @(posedge clk) begin
		if (re) begin
			rdata <= mem_q[raddr];
		end
	end

	// read data qualifier
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			rvalid <= 1'b0;
		end else begin
			rvalid <= re;
		end
	end

endmodule

`default_nettype wire

// ===== rtl/core/pcbs_iou_pipe.sv =====
// ----------------------------------------------------------------------------
// pcbs_iou_pipe
// Four-stage overlap test of one kept box against the candidate per cycle.
// ----------------------------------------------------------------------------
`default_nettype none

module pcbs_iou_pipe #(
	parameter int FRAC_BITS = pcbs_pkg::FRAC_BITS_DEF
) (
	input  wire                                          clk,
	input  wire                                          arst_n,
	input  wire                                          in_valid,
	input  pcbs_pkg::box_t                               kept,
	input  pcbs_pkg::box_t                               cand,
	input  wire  [2*pcbs_pkg::span_width(FRAC_BITS)-1:0] cand_area,
	input  wire  [pcbs_pkg::THR_W-1:0]                   thr,
	output pcbs_pkg::iou_status_t                        status
);
	import pcbs_pkg::*;

	localparam int     SPAN_W = span_width(FRAC_BITS);
	localparam int     AREA_W = 2 * SPAN_W;
	localparam int     UNI_W  = AREA_W + 1;
	localparam int     PROD_W = UNI_W + THR_W;
	localparam coord_t ONE_C  = coord_t'(2 ** FRAC_BITS);

	coord_t ix_lo, ix_hi, iy_lo, iy_hi;
	coord_t iw_raw, ih_raw, kw_raw, kh_raw;

	logic              v_s1, v_s2, v_s3, v_s4;
	logic              match_s1, match_s2, match_s3, match_s4;
	logic [SPAN_W-1:0] iw_s1, ih_s1, kw_s1, kh_s1;
	logic [AREA_W-1:0] inter_s2, karea_s2, inter_s3, inter_s4;
	logic [UNI_W-1:0]  union_s3;
	logic [PROD_W-1:0] rhs_s4;
	logic              nz_s4;

	// intersection edges and raw spans
	always_comb begin
		ix_lo  = (ext_pos(kept.left) > ext_pos(cand.left)) ? ext_pos(kept.left)
		                                                   : ext_pos(cand.left);
		iy_lo  = (ext_pos(kept.top) > ext_pos(cand.top)) ? ext_pos(kept.top)
		                                                 : ext_pos(cand.top);
		ix_hi  = (ext_edge(kept.right) < ext_edge(cand.right)) ? ext_edge(kept.right)
		                                                       : ext_edge(cand.right);
		iy_hi  = (ext_edge(kept.bottom) < ext_edge(cand.bottom)) ? ext_edge(kept.bottom)
		                                                         : ext_edge(cand.bottom);
		iw_raw = ix_hi - ix_lo + ONE_C;
		ih_raw = iy_hi - iy_lo + ONE_C;
		kw_raw = ext_edge(kept.right) - ext_pos(kept.left) + ONE_C;
		kh_raw = ext_edge(kept.bottom) - ext_pos(kept.top) + ONE_C;
	end

	// valid chain
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
			v_s2 <= 1'b0;
			v_s3 <= 1'b0;
			v_s4 <= 1'b0;
		end else begin
			v_s1 <= in_valid;
			v_s2 <= v_s1;
			v_s3 <= v_s2;
			v_s4 <= v_s3;
		end
	end

	// datapath: clip spans, multiply, form union, scale
	always_ff @(posedge clk) begin
		match_s1 <= (kept.cls == cand.cls);
		iw_s1    <= iw_raw[COORD_W-1] ? '0 : iw_raw[SPAN_W-1:0];
		ih_s1    <= ih_raw[COORD_W-1] ? '0 : ih_raw[SPAN_W-1:0];
		kw_s1    <= kw_raw[SPAN_W-1:0];
		kh_s1    <= kh_raw[SPAN_W-1:0];

		match_s2 <= match_s1;
		inter_s2 <= iw_s1 * ih_s1;
		karea_s2 <= kw_s1 * kh_s1;

		match_s3 <= match_s2;
		inter_s3 <= inter_s2;
		union_s3 <= UNI_W'(karea_s2) + UNI_W'(cand_area) - UNI_W'(inter_s2);

		match_s4 <= match_s3;
		inter_s4 <= inter_s3;
		nz_s4    <= (union_s3 != '0);
		rhs_s4   <= PROD_W'(thr) * PROD_W'(union_s3);
	end

	// intersection*256 > threshold*union
	assign status.hit  = v_s4 && match_s4 && nz_s4 &&
	                     (PROD_W'({inter_s4, {IOU_SH{1'b0}}}) > rhs_s4);
	assign status.busy = in_valid || v_s1 || v_s2 || v_s3 || v_s4;

endmodule

`default_nettype wire

// ===== rtl/core/per_class_box_suppression.sv =====
// ----------------------------------------------------------------------------
// per_class_box_suppression
// Greedy per-class non-maximum suppression over a store of kept boxes.
// ----------------------------------------------------------------------------
// Boxes enter on the s_axis channel in descending score order, one beat per
// box; s_axis_tuser[0] marks the first box of a frame and empties the store.
// Each box is tested against every stored box, one stored box per cycle read
// from the kept-box memory into a four-stage overlap pipeline. One result
// beat per box leaves on m_axis: tag, keep flag and store-full flag.
// With N boxes in the store (up to KEPT_MAX), all N are read back, one per
// cycle. Each read passes the registered memory read and then the four
// pipeline stages; once the pipeline has drained, the result beat is
// registered onto m_axis and the block returns to idle to take the next box.
// Only one box is in flight; the next is accepted once the previous result
// sits in the output register, even if the receiver has not taken it yet.
// A kept box is written to the store at the end of its test, so a following
// box never reads an entry that is still being written.
// If m_axis_tready stays low with a result pending, the next box finishes
// its test and then waits for the output register.
// Reset empties the store and sets the overlap threshold to 115/256.
// cfg_wr_en/cfg_wr_data write the threshold; write it only while idle.
// ----------------------------------------------------------------------------
`default_nettype none

module per_class_box_suppression #(
	parameter int KEPT_MAX  = pcbs_pkg::KEPT_MAX_DEF,
	parameter int FRAC_BITS = pcbs_pkg::FRAC_BITS_DEF
) (
	input  wire                        clk,
	input  wire                        arst_n,
	// threshold register
	input  wire                        cfg_wr_en,
	input  wire  [pcbs_pkg::THR_W-1:0] cfg_wr_data,
	// box input
	input  wire                        s_axis_tvalid,
	output logic                       s_axis_tready,
	// box_left, box_top, box_width, box_height, class_id, box_tag, zero pad
	input  wire  [87:0]                s_axis_tdata,
	// first_box
	input  wire  [0:0]                 s_axis_tuser,
	// result output
	output logic                       m_axis_tvalid,
	input  wire                        m_axis_tready,
	// out_tag, keep, store_full, zero pad
	output logic [23:0]                m_axis_tdata
);
	import pcbs_pkg::*;

	localparam int     ADDR_W = $clog2(KEPT_MAX);
	localparam int     CNT_W  = $clog2(KEPT_MAX + 1);
	localparam int     SPAN_W = span_width(FRAC_BITS);
	localparam int     AREA_W = 2 * SPAN_W;
	localparam logic [CNT_W-1:0]  CNT_MAX = CNT_W'(KEPT_MAX);
	localparam logic [SPAN_W-1:0] ONE_S   = SPAN_W'(2 ** FRAC_BITS);

	typedef enum logic [1:0] {
		ST_IDLE,
		ST_SCAN,
		ST_FINISH
	} state_t;

	state_t            state_q;
	logic [CNT_W-1:0]  count_q;
	logic [CNT_W-1:0]  rd_idx_q;
	logic              suppress_q;
	logic [THR_W-1:0]  thr_q;
	logic              m_valid_q;

	box_t              cand_q;
	logic [TAG_W-1:0]  tag_q;
	logic [SPAN_W-1:0] span_w_q, span_h_q;
	logic [AREA_W-1:0] cand_area_q;
	logic [TAG_W-1:0]  out_tag_q;
	logic              out_keep_q, out_full_q;

	logic              in_beat, out_free, scan_rd, finish_go, mem_we;
	logic [POS_W-1:0]  in_left, in_top, in_width, in_height;
	logic [CLASS_W-1:0] in_class;
	logic [TAG_W-1:0]  in_tag;

	box_t              kept_rd;
	logic              kept_rvalid;
	iou_status_t       pipe_st;

	// input beat unpacking
	assign in_left   = s_axis_tdata[15:0];
	assign in_top    = s_axis_tdata[31:16];
	assign in_width  = s_axis_tdata[47:32];
	assign in_height = s_axis_tdata[63:48];
	assign in_class  = s_axis_tdata[70:64];
	assign in_tag    = s_axis_tdata[86:71];

	// handshake and control strobes
	assign s_axis_tready = (state_q == ST_IDLE);
	assign in_beat       = s_axis_tvalid && s_axis_tready;
	assign out_free      = !m_valid_q || m_axis_tready;
	assign scan_rd       = (state_q == ST_SCAN) && (rd_idx_q != count_q);
	assign finish_go     = (state_q == ST_FINISH) && !pipe_st.busy && out_free;
	assign mem_we        = finish_go && !suppress_q && (count_q != CNT_MAX);

	// controller: state, store count, read index, output valid
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q    <= ST_IDLE;
			count_q    <= '0;
			rd_idx_q   <= '0;
			suppress_q <= 1'b0;
			m_valid_q  <= 1'b0;
		end else begin
			if (m_valid_q && m_axis_tready) begin
				m_valid_q <= 1'b0;
			end
			unique case (state_q)
				ST_IDLE: begin
					if (in_beat) begin
						if (s_axis_tuser[0]) begin
							count_q <= '0;
						end
						rd_idx_q   <= '0;
						suppress_q <= 1'b0;
						state_q    <= ST_SCAN;
					end
				end
				ST_SCAN: begin
					suppress_q <= suppress_q | pipe_st.hit;
					if (scan_rd) begin
						rd_idx_q <= rd_idx_q + CNT_W'(1);
					end else begin
						state_q <= ST_FINISH;
					end
				end
				ST_FINISH: begin
					suppress_q <= suppress_q | pipe_st.hit;
					if (finish_go) begin
						m_valid_q <= 1'b1;
						if (mem_we) begin
							count_q <= count_q + CNT_W'(1);
						end
						state_q <= ST_IDLE;
					end
				end
				default: begin
					state_q <= ST_IDLE;
				end
			endcase
		end
	end

	// threshold register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			thr_q <= THR_RESET;
		end else if (cfg_wr_en) begin
			thr_q <= cfg_wr_data;
		end
	end

	// candidate box capture
	always_ff @(posedge clk) begin
		if (in_beat) begin
			cand_q.left   <= $signed(in_left);
			cand_q.top    <= $signed(in_top);
			cand_q.right  <= $signed({{2{in_left[POS_W-1]}}, in_left} + {2'b00, in_width});
			cand_q.bottom <= $signed({{2{in_top[POS_W-1]}}, in_top} + {2'b00, in_height});
			cand_q.cls    <= in_class;
			tag_q         <= in_tag;
			span_w_q      <= SPAN_W'(in_width) + ONE_S;
			span_h_q      <= SPAN_W'(in_height) + ONE_S;
		end
		cand_area_q <= span_w_q * span_h_q;
	end

	// result register
	always_ff @(posedge clk) begin
		if (finish_go) begin
			out_tag_q  <= tag_q;
			out_keep_q <= !suppress_q;
			out_full_q <= !suppress_q && (count_q == CNT_MAX);
		end
	end

	assign m_axis_tvalid = m_valid_q;
	assign m_axis_tdata  = {6'd0, out_full_q, out_keep_q, out_tag_q};

	pcbs_kept_mem #(
		.DEPTH (KEPT_MAX)
	) u_kept_mem (
		.clk    (clk),
		.arst_n (arst_n),
		.we     (mem_we),
		.waddr  (count_q[ADDR_W-1:0]),
		.wdata  (cand_q),
		.re     (scan_rd),
		.raddr  (rd_idx_q[ADDR_W-1:0]),
		.rdata  (kept_rd),
		.rvalid (kept_rvalid)
	);

	pcbs_iou_pipe #(
		.FRAC_BITS (FRAC_BITS)
	) u_iou_pipe (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (kept_rvalid),
		.kept      (kept_rd),
		.cand      (cand_q),
		.cand_area (cand_area_q),
		.thr       (thr_q),
		.status    (pipe_st)
	);

	// checks
	a_store_bound: assert property (@(posedge clk) disable iff (!arst_n)
		mem_we |-> (count_q < CNT_MAX))
		else $error("store written while full");

	a_idle_drained: assert property (@(posedge clk) disable iff (!arst_n)
		s_axis_tready |-> !pipe_st.busy)
		else $error("input ready while overlap pipeline busy");

	a_scan_index: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == ST_SCAN) |-> (rd_idx_q <= count_q))
		else $error("read index beyond store count");

	a_result_src: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(m_valid_q) |-> $past(state_q == ST_FINISH))
		else $error("result raised outside finish state");

endmodule

`default_nettype wire

// ===== bench/tb.sv =====
// ----------------------------------------------------------------------------
// tb
// Self-checking bench for the per-class box suppression block.
// ----------------------------------------------------------------------------
// Boxes are streamed in with random bursts and gaps, while the result side
// stalls on a changing pattern of its own. An in-bench predictor keeps its
// own store of kept boxes and the threshold, and works out the verdict for
// every accepted box beat. Each result beat is checked against the oldest
// pending verdict. Directed tests cover field extremes, threshold extremes,
// frames without a first flag and a full store; random frames follow under
// several thresholds.
// ----------------------------------------------------------------------------

module tb;
	timeunit 1ns;
	timeprecision 1ps;

	import pcbs_pkg::*;

	localparam int  STORE_DEPTH  = KEPT_MAX_DEF;
	localparam int  ONE_PIXEL    = 1 << FRAC_BITS_DEF;
	localparam int  CYCLE_LIMIT  = 1000000;
	localparam int  MAX_REPORTED = 10;
	localparam int  DRAIN_CYCLES = 80;

	// one box beat, fields as the block sees them
	typedef struct packed {
		logic                    first;
		logic signed [POS_W-1:0] left;
		logic signed [POS_W-1:0] top;
		logic [POS_W-1:0]        wid;
		logic [POS_W-1:0]        hgt;
		logic [CLASS_W-1:0]      cls;
		logic [TAG_W-1:0]        tag;
	} box_beat_t;

	// one result beat
	typedef struct packed {
		logic [TAG_W-1:0] tag;
		logic             keep;
		logic             full;
	} verdict_t;

	logic             clk           = 1'b0;
	logic             arst_n        = 1'b0;
	logic             cfg_wr_en     = 1'b0;
	logic [THR_W-1:0] cfg_wr_data   = '0;
	logic             s_axis_tvalid = 1'b0;
	logic             s_axis_tready;
	// box_left, box_top, box_width, box_height, class_id, box_tag, zero pad
	logic [87:0]      s_axis_tdata  = '0;
	// first_box
	logic [0:0]       s_axis_tuser  = '0;
	logic             m_axis_tvalid;
	logic             m_axis_tready = 1'b0;
	// out_tag, keep, store_full, zero pad
	logic [23:0]      m_axis_tdata;

	// predictor state
	longint           kept_l   [STORE_DEPTH];
	longint           kept_t   [STORE_DEPTH];
	longint           kept_r   [STORE_DEPTH];
	longint           kept_b   [STORE_DEPTH];
	logic [CLASS_W-1:0] kept_cls [STORE_DEPTH];
	int               kept_n        = 0;
	logic [THR_W-1:0] cur_threshold = THR_RESET;

	verdict_t         verdicts_due[$];
	verdict_t         got_v, want_v;
	int               fail_cnt   = 0;
	int               burst_left = 0;
	longint           cycle_cnt  = 0;

	per_class_box_suppression u_dut (
		.clk           (clk),
		.arst_n        (arst_n),
		.cfg_wr_en     (cfg_wr_en),
		.cfg_wr_data   (cfg_wr_data),
		.s_axis_tvalid (s_axis_tvalid),
		.s_axis_tready (s_axis_tready),
		.s_axis_tdata  (s_axis_tdata),
		.s_axis_tuser  (s_axis_tuser),
		.m_axis_tvalid (m_axis_tvalid),
		.m_axis_tready (m_axis_tready),
		.m_axis_tdata  (m_axis_tdata)
	);

	// 4 ns clock
	always begin
		#2 clk = 1'b1;
		#2 clk = 1'b0;
	end

	// run limit
	always @(posedge clk) begin
		cycle_cnt <= cycle_cnt + 1;
		if (cycle_cnt >= CYCLE_LIMIT) begin
			$display("FAIL per_class_box_suppression");
			$finish;
		end
	end

	// ------------------------------------------------------------------------
	// predictor
	// ------------------------------------------------------------------------

	// inclusive-span IoU test against the current threshold
	function automatic bit boxes_clash(longint l0, longint t0, longint r0, longint b0,
			longint l1, longint t1, longint r1, longint b1);
		longint w, h, inter, uni;
		w = ((r0 < r1) ? r0 : r1) - ((l0 > l1) ? l0 : l1) + ONE_PIXEL;
		h = ((b0 < b1) ? b0 : b1) - ((t0 > t1) ? t0 : t1) + ONE_PIXEL;
		if (w < 0)
			w = 0;
		if (h < 0)
			h = 0;
		inter = w * h;
		uni = (r0 - l0 + ONE_PIXEL) * (b0 - t0 + ONE_PIXEL)
			+ (r1 - l1 + ONE_PIXEL) * (b1 - t1 + ONE_PIXEL) - inter;
		if (uni <= 0)
			return 1'b0;
		return (inter * 256) > (longint'(cur_threshold) * uni);
	endfunction

	// verdict for one box; updates the predicted store
	function automatic verdict_t judge_box(box_beat_t bx);
		longint   l, t, r, b;
		verdict_t v;
		l = longint'($signed(bx.left));
		t = longint'($signed(bx.top));
		r = l + longint'(bx.wid);
		b = t + longint'(bx.hgt);
		v.tag  = bx.tag;
		v.keep = 1'b1;
		v.full = 1'b0;
		if (bx.first)
			kept_n = 0;
		for (int k = 0; k < kept_n; k++) begin
			if (kept_cls[k] == bx.cls &&
					boxes_clash(kept_l[k], kept_t[k], kept_r[k], kept_b[k], l, t, r, b)) begin
				v.keep = 1'b0;
				break;
			end
		end
		if (v.keep) begin
			if (kept_n < STORE_DEPTH) begin
				kept_l[kept_n]   = l;
				kept_t[kept_n]   = t;
				kept_r[kept_n]   = r;
				kept_b[kept_n]   = b;
				kept_cls[kept_n] = bx.cls;
				kept_n++;
			end else begin
				v.full = 1'b1;
			end
		end
		return v;
	endfunction

	// append a verdict behind the ones still waiting
	task automatic queue_verdict(input verdict_t v);
		verdicts_due.insert(verdicts_due.size(), v);
	endtask

	// ------------------------------------------------------------------------
	// result side: stall pattern and checker
	// ------------------------------------------------------------------------

	// receiver changes its stall habit after each run of random length
	initial begin
		int mode, run_len;
		forever begin
			mode    = $urandom_range(0, 3);
			run_len = $urandom_range(20, 300);
			repeat (run_len) begin
				@(negedge clk);
				case (mode)
					0: begin
						m_axis_tready <= 1'b1;
					end
					1: begin
						m_axis_tready <= 1'($urandom_range(0, 1));
					end
					2: begin
						m_axis_tready <= ($urandom_range(0, 7) != 0);
					end
					default: begin
						m_axis_tready <= ($urandom_range(0, 15) == 0);
					end
				endcase
			end
		end
	end

	task automatic report_failure(input string what, input verdict_t w, input verdict_t g);
		fail_cnt++;
		if (fail_cnt <= MAX_REPORTED)
			$display("%0t: %s: expected tag %h keep %b full %b, got tag %h keep %b full %b",
				$time, what, w.tag, w.keep, w.full, g.tag, g.keep, g.full);
	endtask

	// compare every result beat with the oldest pending verdict
	always @(posedge clk) begin
		if (arst_n && m_axis_tvalid && m_axis_tready) begin
			got_v.tag  = m_axis_tdata[15:0];
			got_v.keep = m_axis_tdata[16];
			got_v.full = m_axis_tdata[17];
			if (verdicts_due.size() == 0) begin
				report_failure("result beat with no box pending", '0, got_v);
			end else begin
				want_v = verdicts_due.pop_front();
				if (got_v.tag !== want_v.tag)
					report_failure("out_tag mismatch", want_v, got_v);
				else if (got_v.keep !== want_v.keep)
					report_failure("keep mismatch", want_v, got_v);
				else if (got_v.full !== want_v.full)
					report_failure("store_full mismatch", want_v, got_v);
			end
		end
	end

	// ------------------------------------------------------------------------
	// box side
	// ------------------------------------------------------------------------

	// send one box beat, idling between bursts
	task automatic send_box(input box_beat_t bx);
		if (burst_left == 0) begin
			burst_left = ($urandom_range(0, 4) == 0) ? $urandom_range(20, 60)
				: $urandom_range(1, 12);
			if ($urandom_range(0, 3) != 0) begin
				@(negedge clk);
				s_axis_tvalid <= 1'b0;
				repeat ($urandom_range(0, 8))
					@(negedge clk);
			end
		end
		burst_left--;
		@(negedge clk);
		s_axis_tvalid <= 1'b1;
		s_axis_tuser  <= bx.first;
		s_axis_tdata  <= {1'b0, bx.tag, bx.cls, bx.hgt, bx.wid, bx.top, bx.left};
		@(posedge clk);
		while (!s_axis_tready)
			@(posedge clk);
		queue_verdict(judge_box(bx));
	endtask

	// stop sending and wait for every pending result
	task automatic drain_results();
		@(negedge clk);
		s_axis_tvalid <= 1'b0;
		burst_left = 0;
		while (verdicts_due.size() != 0)
			@(posedge clk);
	endtask

	task automatic set_threshold(input logic [THR_W-1:0] thr);
		drain_results();
		@(negedge clk);
		cfg_wr_en   <= 1'b1;
		cfg_wr_data <= thr;
		@(negedge clk);
		cfg_wr_en   <= 1'b0;
		cur_threshold = thr;
	endtask

	function automatic box_beat_t mk_box(input bit first, input int l, input int t,
			input int w, input int h, input int cls);
		box_beat_t bx;
		bx.first = first;
		bx.left  = l[POS_W-1:0];
		bx.top   = t[POS_W-1:0];
		bx.wid   = w[POS_W-1:0];
		bx.hgt   = h[POS_W-1:0];
		bx.cls   = cls[CLASS_W-1:0];
		bx.tag   = TAG_W'($urandom_range(0, 65535));
		return bx;
	endfunction

	// ------------------------------------------------------------------------
	// tests
	// ------------------------------------------------------------------------

	// coordinate and size extremes, class edges, out-of-range classes
	task automatic test_field_extremes();
		box_beat_t bx;
		bx = mk_box(1, -32768, -32768, 0, 0, 0);
		bx.tag = '0;
		send_box(bx);
		bx = mk_box(0, 32767, 32767, 65535, 65535, 127);
		bx.tag = '1;
		send_box(bx);
		// same extreme box again: suppressed
		send_box(mk_box(0, 32767, 32767, 65535, 65535, 127));
		send_box(mk_box(0, -32768, -32768, 0, 0, 79));
		send_box(mk_box(0, -32768, -32768, 0, 0, 0));
		// classes beyond the class count still compare by code
		send_box(mk_box(0, 1000, 1000, 320, 320, 80));
		send_box(mk_box(0, 1000, 1000, 320, 320, 80));
		send_box(mk_box(0, 1000, 1000, 320, 320, 81));
		// half shift stays under the default limit, quarter shift exceeds it
		send_box(mk_box(0, 1160, 1000, 320, 320, 80));
		send_box(mk_box(0, 1080, 1000, 320, 320, 80));
	endtask

	// zero threshold, unit-scale threshold and one below it
	task automatic test_threshold_extremes();
		set_threshold(0);
		send_box(mk_box(1, 0, 0, 320, 320, 3));
		// touching edges share one inclusive pixel column
		send_box(mk_box(0, 320, 0, 320, 320, 3));
		// one pixel apart: no overlap at all
		send_box(mk_box(0, 336, 0, 320, 320, 3));
		set_threshold(256);
		send_box(mk_box(1, -5000, 200, 640, 480, 9));
		send_box(mk_box(0, -5000, 200, 640, 480, 9));
		send_box(mk_box(0, -5000, 200, 640, 480, 9));
		set_threshold(255);
		send_box(mk_box(0, -5000, 200, 640, 480, 9));
		set_threshold(THR_RESET);
	endtask

	// store carries over when a frame starts without the first flag
	task automatic test_open_frames();
		send_box(mk_box(1, 4000, -4000, 800, 800, 12));
		send_box(mk_box(0, 9000, -4000, 800, 800, 12));
		send_box(mk_box(0, 4000, -4000, 800, 800, 12));
		send_box(mk_box(1, 4000, -4000, 800, 800, 12));
	endtask

	// fill the store, then overflow it
	task automatic test_store_full();
		for (int k = 0; k < STORE_DEPTH + 2; k++)
			send_box(mk_box(k == 0, -30000 + k * 900, 100, 400, 400, 5));
		// copy of a stored box is suppressed
		send_box(mk_box(0, -30000, 100, 400, 400, 5));
		// copy of a box that found no room is kept again, still no room
		send_box(mk_box(0, -30000 + STORE_DEPTH * 900, 100, 400, 400, 5));
	endtask

	// random frames of clustered boxes with some noise and broken frames
	task automatic run_frames(input int n_items);
		int        sent, flen, ncl, c, fresh_pct;
		int        cx[4], cy[4], cw[4], ch[4], ccl[4];
		bit        broken;
		logic [31:0] r0, r1;
		box_beat_t bx;
		sent = 0;
		while (sent < n_items) begin
			if ($urandom_range(0, 9) == 0) begin
				// noise beat: every field at random
				r0 = $urandom;
				r1 = $urandom;
				bx.first = 1'($urandom_range(0, 1));
				bx.left  = r0[15:0];
				bx.top   = r0[31:16];
				bx.wid   = r1[15:0];
				bx.hgt   = r1[31:16];
				bx.cls   = CLASS_W'($urandom_range(0, 127));
				bx.tag   = TAG_W'($urandom_range(0, 65535));
				send_box(bx);
				sent++;
			end else begin
				if ($urandom_range(0, 24) == 0) begin
					flen      = $urandom_range(66, 100);
					fresh_pct = 80;
				end else begin
					flen      = $urandom_range(1, 24);
					fresh_pct = 30;
				end
				broken = ($urandom_range(0, 7) == 0);
				ncl    = $urandom_range(1, 4);
				for (int i = 0; i < ncl; i++) begin
					cx[i]  = $urandom_range(0, 58000) - 30000;
					cy[i]  = $urandom_range(0, 58000) - 30000;
					cw[i]  = $urandom_range(16, 2000);
					ch[i]  = $urandom_range(16, 2000);
					ccl[i] = ($urandom_range(0, 9) == 0) ? $urandom_range(0, 127)
						: $urandom_range(0, 3);
				end
				for (int i = 0; i < flen; i++) begin
					c = $urandom_range(0, ncl - 1);
					if ($urandom_range(1, 100) <= fresh_pct) begin
						bx = mk_box(0, $urandom_range(0, 58000) - 30000,
							$urandom_range(0, 58000) - 30000,
							$urandom_range(16, 1500), $urandom_range(16, 1500), ccl[c]);
					end else begin
						bx = mk_box(0,
							cx[c] + $urandom_range(0, cw[c] / 2) - cw[c] / 4,
							cy[c] + $urandom_range(0, ch[c] / 2) - ch[c] / 4,
							cw[c] + $urandom_range(0, cw[c] / 2) - cw[c] / 4,
							ch[c] + $urandom_range(0, ch[c] / 2) - ch[c] / 4, ccl[c]);
					end
					bx.first = (i == 0) && !broken;
					send_box(bx);
					sent++;
				end
			end
		end
	endtask

	// several threshold phases, extremes among them
	task automatic test_random_traffic();
		set_threshold(0);
		run_frames(230);
		set_threshold(256);
		run_frames(230);
		set_threshold(128);
		run_frames(270);
		set_threshold(THR_W'($urandom_range(1, 255)));
		run_frames(270);
		set_threshold(THR_RESET);
		run_frames(320);
	endtask

	// ------------------------------------------------------------------------
	// sequence
	// ------------------------------------------------------------------------
	initial begin
		repeat (4)
			@(posedge clk);
		@(negedge clk);
		arst_n <= 1'b1;
		test_field_extremes();
		test_threshold_extremes();
		test_open_frames();
		test_store_full();
		test_random_traffic();
		drain_results();
		repeat (DRAIN_CYCLES)
			@(posedge clk);
		if (fail_cnt == 0)
			$display("PASS per_class_box_suppression");
		else
			$display("FAIL per_class_box_suppression");
		$finish;
	end

endmodule
